@@ rtl/pdsc_pkg.sv @@
`timescale 1ns / 1ps

package pdsc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [6:0]  PHASE_LAST      = 7'd99;
    localparam logic [6:0]  DUTY_MAX        = 7'd100;
    localparam logic [15:0] RST_INTERVAL    = 16'd1000;
    localparam logic [6:0]  RST_MANUAL_STEP = 7'd5;
    localparam logic [6:0]  RST_UP_STEP     = 7'd1;
    localparam logic [6:0]  RST_DOWN_STEP   = 7'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_UPDATE_INTERVAL = 2'd0,
        CFG_MANUAL_STEP     = 2'd1,
        CFG_RAMP_UP_STEP    = 2'd2,
        CFG_RAMP_DOWN_STEP  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic key_toggle_mode;
        logic key_decrease;
        logic key_increase;
    } t_in_item;

    typedef struct packed {
        logic       pwm_on;
        logic [6:0] duty_percent;
        logic       mode_auto;
    } t_out_item;

    typedef struct packed {
        logic [15:0] update_interval;
        logic [6:0]  manual_step;
        logic [6:0]  ramp_up_step;
        logic [6:0]  ramp_down_step;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  phase;
        logic [15:0] countdown;
        logic [6:0]  duty;
        logic        ramp_rising;
        logic        auto_mode;
    } t_state;

endpackage

@@ rtl/pdsc_cfg_regs.sv @@
`timescale 1ns / 1ps

module pdsc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdsc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pdsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pdsc_pkg::t_cfg                     o_cfg
);

    pdsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_interval <= pdsc_pkg::RST_INTERVAL;
            r_cfg.manual_step     <= pdsc_pkg::RST_MANUAL_STEP;
            r_cfg.ramp_up_step    <= pdsc_pkg::RST_UP_STEP;
            r_cfg.ramp_down_step  <= pdsc_pkg::RST_DOWN_STEP;
        end else if (i_cfg_we) begin
            case (pdsc_pkg::t_cfg_index'(i_cfg_index))
                pdsc_pkg::CFG_UPDATE_INTERVAL: begin
                    r_cfg.update_interval <= i_cfg_data;
                end
                pdsc_pkg::CFG_MANUAL_STEP: begin
                    r_cfg.manual_step <= i_cfg_data[6:0];
                end
                pdsc_pkg::CFG_RAMP_UP_STEP: begin
                    r_cfg.ramp_up_step <= i_cfg_data[6:0];
                end
                pdsc_pkg::CFG_RAMP_DOWN_STEP: begin
                    r_cfg.ramp_down_step <= i_cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pdsc_step_logic.sv @@
`timescale 1ns / 1ps

module pdsc_step_logic (
    input  pdsc_pkg::t_state    i_state,
    input  pdsc_pkg::t_cfg      i_cfg,
    input  pdsc_pkg::t_in_item  i_item,
    output pdsc_pkg::t_state    o_state,
    output pdsc_pkg::t_out_item o_item
);

    function automatic logic [6:0] sat_add(input logic [6:0] d, input logic [6:0] s);
        logic [7:0] sum;
        sum = {1'b0, d} + {1'b0, s};
        return (sum > {1'b0, pdsc_pkg::DUTY_MAX}) ? pdsc_pkg::DUTY_MAX : sum[6:0];
    endfunction

    function automatic logic [6:0] sat_sub(input logic [6:0] d, input logic [6:0] s);
        return (d <= s) ? 7'd0 : d - s;
    endfunction

    logic       tog;
    logic       fire;
    logic       auto_n;
    logic       rise_n;
    logic [6:0] duty_auto;
    logic [6:0] duty_n;

    always_comb begin
        tog  = i_item.key_toggle_mode;
        fire = (i_state.countdown == 16'd0);

        auto_n = i_state.auto_mode ^ tog;

        if (i_state.duty >= pdsc_pkg::DUTY_MAX) begin
            rise_n = 1'b0;
        end else if (i_state.duty == 7'd0) begin
            rise_n = 1'b1;
        end else begin
            rise_n = i_state.ramp_rising;
        end

        duty_auto = i_state.duty;
        if (fire && auto_n) begin
            duty_auto = rise_n ? sat_add(i_state.duty, i_cfg.ramp_up_step)
                               : sat_sub(i_state.duty, i_cfg.ramp_down_step);
        end

        // The toggle key cancels both step keys for the tick it is pressed.
        duty_n = duty_auto;
        if (!auto_n && !tog) begin
            if (i_item.key_decrease) begin
                duty_n = sat_sub(duty_auto, i_cfg.manual_step);
            end else if (i_item.key_increase) begin
                duty_n = sat_add(duty_auto, i_cfg.manual_step);
            end
        end

        o_state.phase = (i_state.phase >= pdsc_pkg::PHASE_LAST) ? 7'd0
                                                                : i_state.phase + 7'd1;
        if (fire) begin
            o_state.countdown = (i_cfg.update_interval == 16'd0) ? 16'd0
                                                                 : i_cfg.update_interval - 16'd1;
        end else begin
            o_state.countdown = i_state.countdown - 16'd1;
        end
        o_state.duty        = duty_n;
        o_state.ramp_rising = rise_n;
        o_state.auto_mode   = auto_n;

        o_item.pwm_on       = (i_state.phase < i_state.duty);
        o_item.duty_percent = duty_n;
        o_item.mode_auto    = auto_n;
    end

endmodule

@@ rtl/pwm_duty_sweep_controller_core.sv @@
`timescale 1ns / 1ps
// An accepted item's result is loaded into the output register in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; the single output register frees in the cycle it is taken.
// Each tick's full update is one combinational pass from the state registers.
// Reset (synchronous, active low) loads the register defaults, clears phase, countdown
// and duty, sets auto mode with a rising ramp, and empties the output register.
module pwm_duty_sweep_controller_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pdsc_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pdsc_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [pdsc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pdsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pdsc_pkg::t_cfg      cfg;
    pdsc_pkg::t_state    r_state;
    pdsc_pkg::t_state    n_state;
    pdsc_pkg::t_out_item r_out;
    pdsc_pkg::t_out_item n_out;
    logic                r_out_valid;
    logic                in_accept;

    pdsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdsc_step_logic u_step (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_item  (n_out)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= 7'd0;
            r_state.countdown   <= 16'd0;
            r_state.duty        <= 7'd0;
            r_state.ramp_rising <= 1'b1;
            r_state.auto_mode   <= 1'b1;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_out_item.duty_percent == r_state.duty
                       && o_out_item.mode_auto == r_state.auto_mode))
        else $error("result does not reflect updated state");

    a_phase_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state.phase == (($past(r_state.phase) >= pdsc_pkg::PHASE_LAST)
                                         ? 7'd0 : $past(r_state.phase) + 7'd1)))
        else $error("phase did not advance by one tick");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_state))
        else $error("state changed without an accepted item");

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.duty_percent <= pdsc_pkg::DUTY_MAX))
        else $error("duty out of range");

endmodule

@@ tb/pwm_duty_sweep_controller_core_tb.sv @@
`timescale 1ns / 1ps

module pwm_duty_sweep_controller_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 16;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 145;

    class pwm_tick_scoreboard;
        pdsc_pkg::t_cfg      cfg;
        logic [6:0]          phase;
        logic [15:0]         countdown;
        logic [6:0]          duty;
        logic                rising;
        logic                auto_on;
        pdsc_pkg::t_out_item expected_q[$];
        int                  errors;

        function new();
            cfg.update_interval = pdsc_pkg::RST_INTERVAL;
            cfg.manual_step     = pdsc_pkg::RST_MANUAL_STEP;
            cfg.ramp_up_step    = pdsc_pkg::RST_UP_STEP;
            cfg.ramp_down_step  = pdsc_pkg::RST_DOWN_STEP;
            phase     = '0;
            countdown = '0;
            duty      = '0;
            rising    = 1'b1;
            auto_on   = 1'b1;
            errors    = 0;
        endfunction

        function void write_reg(pdsc_pkg::t_cfg_index idx, logic [15:0] data);
            case (idx)
                pdsc_pkg::CFG_UPDATE_INTERVAL: cfg.update_interval = data;
                pdsc_pkg::CFG_MANUAL_STEP:     cfg.manual_step     = data[6:0];
                pdsc_pkg::CFG_RAMP_UP_STEP:    cfg.ramp_up_step    = data[6:0];
                pdsc_pkg::CFG_RAMP_DOWN_STEP:  cfg.ramp_down_step  = data[6:0];
                default: ;
            endcase
        endfunction

        function logic [6:0] duty_up(logic [6:0] d, logic [6:0] step);
            int sum;
            sum = int'(d) + int'(step);
            return (sum > int'(pdsc_pkg::DUTY_MAX)) ? pdsc_pkg::DUTY_MAX : 7'(sum);
        endfunction

        function logic [6:0] duty_down(logic [6:0] d, logic [6:0] step);
            return (d <= step) ? 7'd0 : d - step;
        endfunction

        // Advances the model by one tick and queues the result it must produce.
        function void note_tick(pdsc_pkg::t_in_item keys);
            pdsc_pkg::t_out_item want;
            want.pwm_on = (phase < duty);
            phase = (phase >= pdsc_pkg::PHASE_LAST) ? 7'd0 : phase + 7'd1;
            if (keys.key_toggle_mode)
                auto_on = ~auto_on;
            if (duty >= pdsc_pkg::DUTY_MAX)
                rising = 1'b0;
            else if (duty == 7'd0)
                rising = 1'b1;
            if (countdown == 16'd0) begin
                if (auto_on)
                    duty = rising ? duty_up(duty, cfg.ramp_up_step)
                                  : duty_down(duty, cfg.ramp_down_step);
                countdown = (cfg.update_interval == 16'd0) ? 16'd0
                                                           : cfg.update_interval - 16'd1;
            end else begin
                countdown = countdown - 16'd1;
            end
            // A toggle press cancels both duty keys for that tick.
            if (!auto_on && !keys.key_toggle_mode) begin
                if (keys.key_decrease)
                    duty = duty_down(duty, cfg.manual_step);
                else if (keys.key_increase)
                    duty = duty_up(duty, cfg.manual_step);
            end
            want.duty_percent = duty;
            want.mode_auto    = auto_on;
            expected_q.push_back(want);
        endfunction

        function void check_result(pdsc_pkg::t_out_item got);
            pdsc_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result with no item pending: pwm=%0d duty=%0d auto=%0d",
                             got.pwm_on, got.duty_percent, got.mode_auto);
                return;
            end
            want = expected_q.pop_front();
            if (got.pwm_on !== want.pwm_on || got.duty_percent !== want.duty_percent ||
                got.mode_auto !== want.mode_auto) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"ERROR: result mismatch: expected pwm=%0d duty=%0d auto=%0d, ",
                              "got pwm=%0d duty=%0d auto=%0d"},
                             want.pwm_on, want.duty_percent, want.mode_auto,
                             got.pwm_on, got.duty_percent, got.mode_auto);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("ERROR: %0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    pdsc_pkg::t_in_item                  i_in_item   = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    pdsc_pkg::t_out_item                 o_out_item;
    logic                                i_cfg_we    = 1'b0;
    logic [pdsc_pkg::CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [pdsc_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;

    pwm_tick_scoreboard tick_sb;
    int cycles      = 0;
    int max_in_gap  = MAX_WAIT;
    int max_out_gap = MAX_WAIT;

    pwm_duty_sweep_controller_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // At least half of the draws are zero so that back-to-back traffic stays common.
    function automatic int draw_wait(int max_w);
        if (max_w == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, max_w);
    endfunction

    task automatic send_tick(pdsc_pkg::t_in_item keys);
        int gap;
        gap = draw_wait(max_in_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= keys;
        do @(posedge i_clk); while (!o_in_ready);
        tick_sb.note_tick(keys);
    endtask

    task automatic collect_results();
        int stall;
        forever begin
            stall = draw_wait(max_out_gap);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tick_sb.check_result(o_out_item);
        end
    endtask

    // Waits until every tick has produced its result, then lets the pipeline settle.
    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        while (tick_sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic load_config(logic [15:0] interval, logic [15:0] manual,
                               logic [15:0] up, logic [15:0] down);
        pdsc_pkg::t_cfg_index idx [4];
        logic [15:0] val [4];
        idx = '{pdsc_pkg::CFG_UPDATE_INTERVAL, pdsc_pkg::CFG_MANUAL_STEP,
                pdsc_pkg::CFG_RAMP_UP_STEP, pdsc_pkg::CFG_RAMP_DOWN_STEP};
        val = '{interval, manual, up, down};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            tick_sb.write_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Step values carry random upper bits, which the 7-bit registers must drop.
    function automatic logic [15:0] pick_step();
        logic [15:0] d;
        d = 16'($urandom);
        case ($urandom_range(0, 5))
            0: d[6:0] = 7'd0;
            1: d[6:0] = 7'd1;
            2, 3: d[6:0] = 7'($urandom_range(1, 20));
            4: d[6:0] = 7'd100;
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [15:0] pick_interval();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1, 2: return 16'd1;
            3, 4: return 16'($urandom_range(2, 6));
            5: return 16'($urandom_range(7, 40));
            6: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pdsc_pkg::t_in_item random_keys(int toggle_pct, int key_pct);
        pdsc_pkg::t_in_item keys;
        keys.key_toggle_mode = ($urandom_range(0, 99) < toggle_pct);
        keys.key_decrease    = ($urandom_range(0, 99) < key_pct);
        keys.key_increase    = ($urandom_range(0, 99) < key_pct);
        return keys;
    endfunction

    initial begin
        // Directed ticks, bit order {toggle, decrease, increase}.
        logic [2:0] reset_ticks [];
        logic [2:0] extreme_ticks [];
        logic [2:0] zero_ticks [];
        int toggle_pct;
        int key_pct;

        reset_ticks = '{3'b000, 3'b100, 3'b001, 3'b001, 3'b010, 3'b011,
                        3'b010, 3'b101, 3'b111, 3'b001, 3'b110};
        extreme_ticks = '{3'b000, 3'b000, 3'b000, 3'b100, 3'b001,
                          3'b001, 3'b010, 3'b100};
        zero_ticks = '{3'b000, 3'b100, 3'b001, 3'b010, 3'b100, 3'b000};

        tick_sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            collect_results();
        join_none

        // Reset defaults: the first tick fires a ramp step, then manual keys and toggles.
        foreach (reset_ticks[k]) send_tick(pdsc_pkg::t_in_item'(reset_ticks[k]));
        drain_ticks();

        // Largest steps and the shortest interval: the ramp bounces between 0 and 100.
        load_config(16'd1, 16'hFFFF, 16'd100, 16'd100);
        foreach (extreme_ticks[k]) send_tick(pdsc_pkg::t_in_item'(extreme_ticks[k]));
        drain_ticks();

        // Zero interval fires every tick; zero steps leave the duty alone.
        load_config(16'd0, 16'd0, 16'd0, 16'd0);
        foreach (zero_ticks[k]) send_tick(pdsc_pkg::t_in_item'(zero_ticks[k]));
        drain_ticks();

        for (int p = 0; p < RAND_PHASES; p++) begin
            load_config(pick_interval(), pick_step(), pick_step(), pick_step());
            max_in_gap  = (p % 3 == 0) ? 0 : MAX_WAIT;
            max_out_gap = (p % 4 == 1) ? 0 : MAX_WAIT;
            case ($urandom_range(0, 3))
                0: toggle_pct = 0;
                1: toggle_pct = 2;
                2: toggle_pct = 10;
                default: toggle_pct = 40;
            endcase
            key_pct = $urandom_range(0, 80);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_tick(random_keys(toggle_pct, key_pct));
            drain_ticks();
        end

        tick_sb.close_out();
        if (tick_sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
